FILE: rtl/i2r_pkg.sv
// shared types, letter codes and digit encoding helpers for the roman numeral converter
`timescale 1ns / 1ps
`default_nettype none

package i2r_pkg;

    localparam int          VALUE_W   = 12;
    localparam int          LETTER_W  = 7;
    localparam int          DIGIT_W   = 4;
    localparam int          POS_W     = 2;
    localparam int          IDX_W     = 2;
    localparam int          LEN_W     = 3;
    localparam int          VALUE_MAX = 3999;

    localparam logic [LETTER_W-1:0] LETTER_I = 7'd73;
    localparam logic [LETTER_W-1:0] LETTER_V = 7'd86;
    localparam logic [LETTER_W-1:0] LETTER_X = 7'd88;
    localparam logic [LETTER_W-1:0] LETTER_L = 7'd76;
    localparam logic [LETTER_W-1:0] LETTER_C = 7'd67;
    localparam logic [LETTER_W-1:0] LETTER_D = 7'd68;
    localparam logic [LETTER_W-1:0] LETTER_M = 7'd77;

    // digit positions from thousands down to units
    localparam int PLACE_WEIGHT [4] = '{1000, 100, 10, 1};

    localparam logic [LETTER_W-1:0] UNIT_LETTER [4] = '{LETTER_M, LETTER_C, LETTER_X, LETTER_I};
    localparam logic [LETTER_W-1:0] FIVE_LETTER [4] = '{LETTER_M, LETTER_D, LETTER_L, LETTER_V};
    localparam logic [LETTER_W-1:0] TEN_LETTER  [4] = '{LETTER_M, LETTER_M, LETTER_C, LETTER_X};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        KIND_UNIT,
        KIND_FIVE,
        KIND_TEN
    } kind_t;

    typedef struct packed {
        logic load;
        logic split;
        logic advance;
        logic next_pos;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_range;
        logic digit_zero;
        logic digit_done;
        logic rem_zero;
    } dp_status_t;

    // number of letters a decimal digit turns into
    function automatic logic [LEN_W-1:0] digit_len(input logic [DIGIT_W-1:0] d);
        logic [LEN_W-1:0] n;
        case (d)
            4'd1:    n = 3'd1;
            4'd2:    n = 3'd2;
            4'd3:    n = 3'd3;
            4'd4:    n = 3'd2;
            4'd5:    n = 3'd1;
            4'd6:    n = 3'd2;
            4'd7:    n = 3'd3;
            4'd8:    n = 3'd4;
            4'd9:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // which letter of the position stands at index i of digit d
    function automatic kind_t letter_kind(input logic [DIGIT_W-1:0] d,
                                          input logic [IDX_W-1:0]   i);
        kind_t k;
        case (d)
            4'd4:                   k = (i == '0) ? KIND_UNIT : KIND_FIVE;
            4'd5, 4'd6, 4'd7, 4'd8: k = (i == '0) ? KIND_FIVE : KIND_UNIT;
            4'd9:                   k = (i == '0) ? KIND_UNIT : KIND_TEN;
            default:                k = KIND_UNIT;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/i2r_ctrl.sv
// controller state machine: sequences digit splits and letter emission
`timescale 1ns / 1ps
`default_nettype none

module i2r_ctrl
    import i2r_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd,
    output logic            busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && status.in_range)
                begin
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                // zero digits give no letters, keep splitting
                if (!status.digit_zero)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.digit_done)
                begin
                    state_next = status.rem_zero ? ST_IDLE : ST_SPLIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
            end
            ST_SPLIT:
            begin
                busy         = 1'b1;
                cmd.split    = 1'b1;
                cmd.next_pos = status.digit_zero;
            end
            ST_EMIT:
            begin
                busy         = 1'b1;
                cmd.emit     = 1'b1;
                cmd.advance  = !status.digit_done;
                cmd.next_pos = status.digit_done;
            end
            default:
            begin
                cmd  = '0;
                busy = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/i2r_dpath.sv
// datapath: remainder, digit position, digit split and letter lookup
`timescale 1ns / 1ps
`default_nettype none

module i2r_dpath
    import i2r_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [VALUE_W-1:0]  value,
    input  wire ctrl_cmd_t           cmd,
    output dp_status_t               status,
    output logic [LETTER_W-1:0]      letter,
    output logic                     last
);

    localparam int WIDE_W = VALUE_W + 2;

    logic [VALUE_W-1:0] rem_reg;
    logic [VALUE_W-1:0] rem_next;
    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;

    logic [DIGIT_W-1:0] lane_digit [4];
    logic [WIDE_W-1:0]  lane_sub   [4];
    logic [DIGIT_W-1:0] split_digit;
    logic [WIDE_W-1:0]  split_sub;
    logic [WIDE_W-1:0]  rem_wide;
    logic [LEN_W-1:0]   cur_len;
    kind_t              cur_kind;

    assign rem_wide = {2'b00, rem_reg};

    // one compare bank per position, each against constant multiples of its weight
    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            lane_digit[p] = '0;
            lane_sub[p]   = '0;
            for (int k = 1; k < 10; k++)
            begin
                if (rem_wide >= WIDE_W'(k * PLACE_WEIGHT[p]))
                begin
                    lane_digit[p] = DIGIT_W'(k);
                    lane_sub[p]   = WIDE_W'(k * PLACE_WEIGHT[p]);
                end
            end
        end
    end

    assign split_digit = lane_digit[pos_reg];
    assign split_sub   = lane_sub[pos_reg];

    assign cur_len  = digit_len(digit_reg);
    assign cur_kind = letter_kind(digit_reg, idx_reg);

    assign status.in_range   = (value != '0) && (value <= VALUE_W'(VALUE_MAX));
    assign status.digit_zero = (split_digit == '0);
    assign status.digit_done = ({1'b0, idx_reg} + 3'd1) == cur_len;
    assign status.rem_zero   = (rem_reg == '0);

    always_comb
    begin
        rem_next   = rem_reg;
        digit_next = digit_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        if (cmd.load)
        begin
            rem_next = value;
            pos_next = '0;
            idx_next = '0;
        end
        else
        begin
            if (cmd.split)
            begin
                rem_next   = VALUE_W'(rem_wide - split_sub);
                digit_next = split_digit;
                idx_next   = '0;
            end
            if (cmd.advance)
            begin
                idx_next = idx_reg + 2'd1;
            end
            if (cmd.next_pos)
            begin
                pos_next = pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        digit_reg <= digit_next;
    end

    always_comb
    begin
        case (cur_kind)
            KIND_UNIT: letter = UNIT_LETTER[pos_reg];
            KIND_FIVE: letter = FIVE_LETTER[pos_reg];
            KIND_TEN:  letter = TEN_LETTER[pos_reg];
            default:   letter = UNIT_LETTER[pos_reg];
        endcase
    end

    // final letter of a digit with nothing left in the lower positions
    assign last = cmd.emit && status.digit_done && status.rem_zero;

endmodule

`default_nettype wire

FILE: rtl/integer_to_roman_numeral.sv
// top level of the integer to roman numeral converter
//
//   channel   signals                  handshake
//   input     value[11:0]              taken when start && !busy
//   result    letter[6:0], last        one cycle each, marked by strobe
//
// an item of value 1..3999 keeps busy high through one split step per digit
// position down to the lowest nonzero digit and one emit step per letter, with
// 3888 the longest; the split compare bank gives the digit for each split step
// a value of 0 or above 3999 is dropped at once and busy stays low
// a new item may start in the cycle after the last letter
// reset clears the controller and the position counters
`timescale 1ns / 1ps
`default_nettype none

module integer_to_roman_numeral
    import i2r_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [VALUE_W-1:0]   value,
    output logic                      strobe,
    output logic [LETTER_W-1:0]       letter,
    output logic                      last
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    i2r_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    i2r_dpath u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .value  (value),
        .cmd    (cmd),
        .status (status),
        .letter (letter),
        .last   (last)
    );

    assign strobe = cmd.emit;

endmodule

`default_nettype wire

FILE: rtl/i2r_checker.sv
// port level checks for the roman numeral converter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module i2r_checker
    import i2r_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic [VALUE_W-1:0]  value,
    input wire logic                strobe,
    input wire logic [LETTER_W-1:0] letter,
    input wire logic                last
);

    // an item in range starts a conversion
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && value != '0 && value <= VALUE_W'(VALUE_MAX)) |=> busy)
        else $error("in-range item did not start a conversion");

    // an out of range item is dropped
    a_reject_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (value == '0 || value > VALUE_W'(VALUE_MAX))) |=> !busy)
        else $error("out of range item was not dropped");

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result strobe while not busy");

    // after the final letter the block goes idle
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> (!strobe && !busy))
        else $error("activity after final letter");

    a_letter_code: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (letter == LETTER_I || letter == LETTER_V || letter == LETTER_X ||
                    letter == LETTER_L || letter == LETTER_C || letter == LETTER_D ||
                    letter == LETTER_M))
        else $error("letter is not a numeral code");

endmodule

bind integer_to_roman_numeral i2r_checker u_i2r_checker (.*);

`default_nettype wire
